@@ design/slbm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbm_pkg
// Shared types and constants of the structured loop bytecode machine.
// ----------------------------------------------------------------------------
package slbm_pkg;

  localparam int unsigned SKIP_W   = 11;
  localparam logic [SKIP_W-1:0] SKIP_MAX = 11'd2047;
  localparam int unsigned WORD_W   = 31;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [3:0] {
    OP_END, OP_WHILE, OP_SET, OP_COPY, OP_SHOW, OP_ADD, OP_SUB, OP_MUL,
    OP_DIV, OP_EQ, OP_GT, OP_OR, OP_NOT, OP_MOD
  } op_t;

  typedef enum logic [2:0] {
    ST_OK, ST_SHOW, ST_HALT, ST_DIVZ, ST_OVF, ST_BADOP, ST_RANGE
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LB, S_OP, S_OPA, S_OPB, S_OPT, S_RX, S_RY, S_EX, S_DIV, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    WS_INIT, WS_LIT, WS_Y, WS_NOT, WS_ALU, WS_DIV
  } wsel_t;

  typedef struct packed {
    logic  prog_we;
    logic  data_we;
    logic  x_load;
    logic  div_start;
    logic  push;
    logic  val_load;
    logic  val_clear;
    wsel_t wsel;
    op_t   alu_op;
  } cmd_t;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic div_done;
  } sts_t;

  function automatic logic [1:0] operand_count(input op_t op);
    logic [1:0] n;
    case (op)
      OP_END:                      n = 2'd0;
      OP_WHILE, OP_SHOW, OP_NOT:   n = 2'd1;
      OP_SET, OP_COPY:             n = 2'd2;
      default:                     n = 2'd3;
    endcase
    return n;
  endfunction

endpackage

@@ design/slbm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbm_in_if / slbm_out_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface slbm_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [30:0] word;
  modport source (output valid, output cmd, output word, input ready);
  modport sink   (input valid, input cmd, input word, output ready);
endinterface

interface slbm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] value;
  modport source (output valid, output status, output value, input ready);
  modport sink   (input valid, input status, input value, output ready);
endinterface

@@ design/slbm_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbm_div
// Radix-2 signed truncating divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slbm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic [31:0] q;
  logic [31:0] r;
  logic [31:0] d;
  logic        neg_q;
  logic        neg_r;
  logic        busy;
  logic [4:0]  cnt;
  logic [32:0] r_sh;
  logic [32:0] diff;

  assign r_sh = {r, q[31]};
  assign diff = r_sh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= x[31] ? (32'd0 - x) : x;
      d     <= y[31] ? (32'd0 - y) : y;
      r     <= '0;
      neg_q <= x[31] ^ y[31];
      neg_r <= x[31];
    end else if (busy) begin
      if (!diff[32]) begin
        r <= diff[31:0];
        q <= {q[30:0], 1'b1};
      end else begin
        r <= r_sh[31:0];
        q <= {q[30:0], 1'b0};
      end
    end
  end

  assign quo = neg_q ? (32'd0 - q) : q;
  assign rem = neg_r ? (32'd0 - r) : r;

endmodule

@@ design/slbm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbm_dp
// Datapath: program and data memories, loop stacks, ALU and divider.
// ----------------------------------------------------------------------------
module slbm_dp #(
  parameter int unsigned PROGRAM_DEPTH = 1024,
  parameter int unsigned DATA_DEPTH    = 1024,
  parameter int unsigned LOOP_DEPTH    = 16,
  localparam int unsigned PA = $clog2(PROGRAM_DEPTH),
  localparam int unsigned IW = $clog2(PROGRAM_DEPTH + 1),
  localparam int unsigned DA = $clog2(DATA_DEPTH),
  localparam int unsigned LA = $clog2(LOOP_DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  slbm_pkg::cmd_t  cmd,
  output slbm_pkg::sts_t  sts,
  input  logic [PA-1:0]   prog_waddr,
  input  logic [30:0]     prog_wdata,
  input  logic [PA-1:0]   prog_raddr,
  output logic [30:0]     prog_rdata,
  input  logic [DA-1:0]   data_waddr,
  input  logic [DA-1:0]   data_raddr,
  input  logic [30:0]     lit,
  input  logic [LA-1:0]   stack_widx,
  input  logic [LA-1:0]   stack_ridx,
  input  logic [IW-1:0]   push_start,
  input  logic [DA-1:0]   push_reg,
  output logic [IW-1:0]   top_start,
  output logic [DA-1:0]   top_reg,
  output logic [31:0]     value
);

  logic [30:0] pmem [PROGRAM_DEPTH];
  logic [31:0] dmem [DATA_DEPTH];
  logic [IW-1:0] st_start [LOOP_DEPTH];
  logic [DA-1:0] st_reg [LOOP_DEPTH];
  logic [31:0] data_rdata;
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] alu;
  logic [31:0] wdata;
  logic [31:0] div_q;
  logic [31:0] div_r;
  logic        div_done;

  always_ff @(posedge clk) begin
    if (cmd.prog_we) begin
      pmem[prog_waddr] <= prog_wdata;
    end
    prog_rdata <= pmem[prog_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.data_we) begin
      dmem[data_waddr] <= wdata;
    end
    data_rdata <= dmem[data_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      st_start[stack_widx] <= push_start;
      st_reg[stack_widx]   <= push_reg;
    end
  end

  assign top_start = st_start[stack_ridx];
  assign top_reg   = st_reg[stack_ridx];
  assign y         = data_rdata;

  always_ff @(posedge clk) begin
    if (cmd.x_load) begin
      x <= data_rdata;
    end
    if (cmd.val_clear) begin
      value <= '0;
    end else if (cmd.val_load) begin
      value <= x;
    end
  end

  always_comb begin
    case (cmd.alu_op)
      slbm_pkg::OP_ADD: alu = x + y;
      slbm_pkg::OP_SUB: alu = x - y;
      slbm_pkg::OP_MUL: alu = x * y;
      slbm_pkg::OP_EQ:  alu = {31'd0, x == y};
      slbm_pkg::OP_GT:  alu = {31'd0, $signed(x) > $signed(y)};
      slbm_pkg::OP_OR:  alu = {31'd0, (x != 32'd0) || (y != 32'd0)};
      default:          alu = '0;
    endcase
  end

  always_comb begin
    case (cmd.wsel)
      slbm_pkg::WS_INIT: wdata = {31'd0, data_waddr == '0};
      slbm_pkg::WS_LIT:  wdata = {1'b0, lit};
      slbm_pkg::WS_Y:    wdata = y;
      slbm_pkg::WS_NOT:  wdata = {31'd0, x == 32'd0};
      slbm_pkg::WS_ALU:  wdata = alu;
      slbm_pkg::WS_DIV:  wdata = (cmd.alu_op == slbm_pkg::OP_MOD) ? div_r : div_q;
      default:           wdata = '0;
    endcase
  end

  slbm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .x     (x),
    .y     (y),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_r)
  );

  assign sts.x_zero   = (x == 32'd0);
  assign sts.y_zero   = (y == 32'd0);
  assign sts.div_done = div_done;

endmodule

@@ design/slbm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbm_ctrl
// Controller: pointer, loop level and skip state, and the step sequencer.
// ----------------------------------------------------------------------------
module slbm_ctrl #(
  parameter int unsigned PROGRAM_DEPTH = 1024,
  parameter int unsigned DATA_DEPTH    = 1024,
  parameter int unsigned LOOP_DEPTH    = 16,
  localparam int unsigned PA = $clog2(PROGRAM_DEPTH),
  localparam int unsigned IW = $clog2(PROGRAM_DEPTH + 1),
  localparam int unsigned DA = $clog2(DATA_DEPTH),
  localparam int unsigned LA = $clog2(LOOP_DEPTH),
  localparam int unsigned LW = $clog2(LOOP_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_cmd,
  input  logic [30:0]     in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_status,
  output slbm_pkg::cmd_t  cmd,
  input  slbm_pkg::sts_t  sts,
  output logic [PA-1:0]   prog_waddr,
  output logic [30:0]     prog_wdata,
  output logic [PA-1:0]   prog_raddr,
  input  logic [30:0]     prog_rdata,
  output logic [DA-1:0]   data_waddr,
  output logic [DA-1:0]   data_raddr,
  output logic [30:0]     lit,
  output logic [LA-1:0]   stack_widx,
  output logic [LA-1:0]   stack_ridx,
  output logic [IW-1:0]   push_start,
  output logic [DA-1:0]   push_reg,
  input  logic [IW-1:0]   top_start,
  input  logic [DA-1:0]   top_reg
);

  localparam logic [slbm_pkg::SKIP_W-1:0] SKIP_ONE = slbm_pkg::SKIP_W'(1);

  slbm_pkg::state_t  state, state_next;
  slbm_pkg::op_t     op;
  slbm_pkg::status_t status;
  slbm_pkg::status_t ex_status;
  logic [IW-1:0] ip;
  logic [IW-1:0] plen;
  logic [slbm_pkg::SKIP_W-1:0] skip;
  logic [LW-1:0] level;
  logic          halted;
  logic [1:0]    opn;
  logic [30:0]   a;
  logic [30:0]   b;
  logic [30:0]   t;
  logic [DA-1:0] clr;
  logic          accept;
  logic          load_ok;
  logic          bad_op;
  slbm_pkg::op_t cur_op;
  logic [1:0]    cur_n;
  logic [IW+1:0] skip_next;
  logic          past_end;
  logic          a_bad;
  logic          b_bad;
  logic          t_bad;
  logic          ex_div;
  logic          lb_zero_stack;
  logic [DA-1:0] lb_addr;

  assign accept   = in_valid && in_ready;
  assign load_ok  = plen < IW'(PROGRAM_DEPTH);
  assign bad_op   = prog_rdata > 31'(slbm_pkg::OP_MOD);
  assign cur_op   = slbm_pkg::op_t'(prog_rdata[3:0]);
  assign cur_n    = slbm_pkg::operand_count(cur_op);
  assign skip_next = {2'b0, ip} + (IW+2)'(cur_n) + (IW+2)'(1);
  assign past_end = ({2'b0, ip} + (IW+2)'(cur_n)) >= {2'b0, plen};
  assign a_bad    = a >= 31'(DATA_DEPTH);
  assign b_bad    = b >= 31'(DATA_DEPTH);
  assign t_bad    = t >= 31'(DATA_DEPTH);
  assign lb_zero_stack = (level == '0);
  assign lb_addr  = lb_zero_stack ? '0 : top_reg;
  assign stack_widx = level[LA-1:0];
  assign stack_ridx = LA'(level - LW'(1));
  assign push_start = IW'(ip + IW'(2));
  assign push_reg   = a[DA-1:0];
  assign prog_waddr = plen[PA-1:0];
  assign prog_wdata = in_word;
  assign lit        = b;
  assign in_ready   = (state == slbm_pkg::S_IDLE);
  assign out_valid  = (state == slbm_pkg::S_OUT);
  assign out_status = status;

  always_comb begin
    ex_status = slbm_pkg::ST_OK;
    ex_div    = 1'b0;
    unique case (op)
      slbm_pkg::OP_WHILE: begin
        if (a_bad) begin
          ex_status = slbm_pkg::ST_RANGE;
        end else if (!sts.x_zero && level >= LW'(LOOP_DEPTH)) begin
          ex_status = slbm_pkg::ST_OVF;
        end
      end
      slbm_pkg::OP_SET, slbm_pkg::OP_NOT: begin
        if (a_bad) ex_status = slbm_pkg::ST_RANGE;
      end
      slbm_pkg::OP_SHOW: begin
        ex_status = a_bad ? slbm_pkg::ST_RANGE : slbm_pkg::ST_SHOW;
      end
      slbm_pkg::OP_COPY: begin
        if (a_bad || b_bad) ex_status = slbm_pkg::ST_RANGE;
      end
      default: begin
        if (a_bad || b_bad || t_bad) begin
          ex_status = slbm_pkg::ST_RANGE;
        end else if (op inside {slbm_pkg::OP_DIV, slbm_pkg::OP_MOD}) begin
          if (sts.y_zero) ex_status = slbm_pkg::ST_DIVZ;
          else ex_div = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      slbm_pkg::S_CLEAR: begin
        if (clr == DA'(DATA_DEPTH - 1)) state_next = slbm_pkg::S_IDLE;
      end
      slbm_pkg::S_IDLE: begin
        if (accept) begin
          if (!in_cmd || halted) state_next = slbm_pkg::S_OUT;
          else if (ip >= plen) state_next = slbm_pkg::S_LB;
          else state_next = slbm_pkg::S_OP;
        end
      end
      slbm_pkg::S_LB: state_next = slbm_pkg::S_OUT;
      slbm_pkg::S_OP: begin
        if (bad_op || skip != '0 || past_end) state_next = slbm_pkg::S_OUT;
        else if (cur_n == 2'd0) state_next = slbm_pkg::S_LB;
        else state_next = slbm_pkg::S_OPA;
      end
      slbm_pkg::S_OPA: state_next = (opn >= 2'd2) ? slbm_pkg::S_OPB : slbm_pkg::S_RX;
      slbm_pkg::S_OPB: state_next = (opn == 2'd3) ? slbm_pkg::S_OPT : slbm_pkg::S_RX;
      slbm_pkg::S_OPT: state_next = slbm_pkg::S_RX;
      slbm_pkg::S_RX:  state_next = slbm_pkg::S_RY;
      slbm_pkg::S_RY:  state_next = slbm_pkg::S_EX;
      slbm_pkg::S_EX:  state_next = ex_div ? slbm_pkg::S_DIV : slbm_pkg::S_OUT;
      slbm_pkg::S_DIV: begin
        if (sts.div_done) state_next = slbm_pkg::S_OUT;
      end
      slbm_pkg::S_OUT: begin
        if (out_ready) state_next = slbm_pkg::S_IDLE;
      end
      default: state_next = slbm_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.wsel   = slbm_pkg::WS_INIT;
    cmd.alu_op = op;
    prog_raddr = ip[PA-1:0];
    data_raddr = lb_addr;
    data_waddr = t[DA-1:0];
    unique case (state)
      slbm_pkg::S_CLEAR: begin
        cmd.data_we = 1'b1;
        data_waddr  = clr;
      end
      slbm_pkg::S_IDLE: begin
        cmd.val_clear = accept;
        cmd.prog_we   = accept && !in_cmd && load_ok;
      end
      slbm_pkg::S_OP:  prog_raddr = PA'(ip + IW'(1));
      slbm_pkg::S_OPA: prog_raddr = PA'(ip + IW'(2));
      slbm_pkg::S_OPB: prog_raddr = PA'(ip + IW'(3));
      slbm_pkg::S_RX:  data_raddr = a[DA-1:0];
      slbm_pkg::S_RY: begin
        cmd.x_load = 1'b1;
        data_raddr = b[DA-1:0];
      end
      slbm_pkg::S_EX: begin
        data_waddr    = a[DA-1:0];
        cmd.div_start = ex_div;
        if (ex_status == slbm_pkg::ST_OK && !ex_div) begin
          unique case (op)
            slbm_pkg::OP_WHILE: cmd.push = !sts.x_zero;
            slbm_pkg::OP_SHOW:  cmd.val_load = 1'b1;
            slbm_pkg::OP_SET: begin
              cmd.data_we = 1'b1;
              cmd.wsel    = slbm_pkg::WS_LIT;
            end
            slbm_pkg::OP_COPY: begin
              cmd.data_we = 1'b1;
              cmd.wsel    = slbm_pkg::WS_Y;
            end
            slbm_pkg::OP_NOT: begin
              cmd.data_we = 1'b1;
              cmd.wsel    = slbm_pkg::WS_NOT;
            end
            default: begin
              cmd.data_we = 1'b1;
              cmd.wsel    = slbm_pkg::WS_ALU;
              data_waddr  = t[DA-1:0];
            end
          endcase
        end else if (ex_status == slbm_pkg::ST_SHOW) begin
          cmd.val_load = 1'b1;
        end
      end
      slbm_pkg::S_DIV: begin
        cmd.data_we = sts.div_done;
        cmd.wsel    = slbm_pkg::WS_DIV;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= slbm_pkg::S_CLEAR;
      clr    <= '0;
      ip     <= '0;
      plen   <= '0;
      skip   <= '0;
      level  <= '0;
      halted <= 1'b0;
      status <= slbm_pkg::ST_OK;
    end else begin
      state <= state_next;
      unique case (state)
        slbm_pkg::S_CLEAR: clr <= clr + DA'(1);
        slbm_pkg::S_IDLE: begin
          if (accept) begin
            status <= slbm_pkg::ST_OK;
            if (!in_cmd) begin
              if (load_ok) plen <= plen + IW'(1);
              else status <= slbm_pkg::ST_RANGE;
            end else if (halted) begin
              status <= slbm_pkg::ST_HALT;
            end else if (ip >= plen) begin
              skip <= '0;
            end
          end
        end
        slbm_pkg::S_LB: begin
          if (lb_zero_stack) begin
            if (!sts.y_zero) ip <= '0;
            else begin
              halted <= 1'b1;
              status <= slbm_pkg::ST_HALT;
            end
          end else if (!sts.y_zero) begin
            ip <= top_start;
          end else begin
            level <= level - LW'(1);
          end
        end
        slbm_pkg::S_OP: begin
          op  <= cur_op;
          opn <= cur_n;
          if (bad_op) begin
            status <= slbm_pkg::ST_BADOP;
            ip     <= ip + IW'(1);
          end else if (skip != '0) begin
            if (cur_op == slbm_pkg::OP_END) skip <= skip - SKIP_ONE;
            else if (cur_op == slbm_pkg::OP_WHILE && skip < slbm_pkg::SKIP_MAX)
              skip <= skip + SKIP_ONE;
            ip <= (skip_next < {2'b0, plen}) ? IW'(skip_next) : plen;
          end else if (past_end) begin
            status <= slbm_pkg::ST_RANGE;
            ip     <= plen;
          end else if (cur_n == 2'd0) begin
            ip <= ip + IW'(1);
          end
        end
        slbm_pkg::S_OPA: a <= prog_rdata;
        slbm_pkg::S_OPB: b <= prog_rdata;
        slbm_pkg::S_OPT: t <= prog_rdata;
        slbm_pkg::S_EX: begin
          status <= ex_status;
          ip     <= ip + IW'(opn) + IW'(1);
          if (op == slbm_pkg::OP_WHILE) begin
            if (ex_status != slbm_pkg::ST_OK || sts.x_zero) skip <= SKIP_ONE;
            else level <= level + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ design/structured_loop_bytecode_machine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// structured_loop_bytecode_machine_unit
// Bytecode machine with structured while loops and a nesting stack.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (sink)  : cmd 0 appends word to the program, cmd 1 runs one step.
//   out_ch (source): one result per request, status and shown value.
// One request is in flight at a time; in_ch.ready is high only when idle.
// Path from the accepting edge to result valid:
//   load, halted step            straight to the result
//   loop-back test               loop-back state (end: after its opcode)
//   skipped or rejected word     opcode fetch, then the result
//   instruction with k operands  opcode, k operands, two data reads, execute
//   div / mod                    as above, then the 32-step divider
// A step can only start once the previous result is taken.
// After reset the data memory is swept, one word per cycle, over all DATA_DEPTH
// words (word 0 set to one, the rest zero); in_ch.ready stays low meanwhile.
// A stalled result holds on out_ch until ready; no request is taken then.
// ----------------------------------------------------------------------------
module structured_loop_bytecode_machine_unit #(
  parameter int unsigned PROGRAM_DEPTH = 1024,
  parameter int unsigned DATA_DEPTH    = 1024,
  parameter int unsigned LOOP_DEPTH    = 16
) (
  input  logic        clk,
  input  logic        rst,
  slbm_in_if.sink     in_ch,
  slbm_out_if.source  out_ch
);

  localparam int unsigned PA = $clog2(PROGRAM_DEPTH);
  localparam int unsigned IW = $clog2(PROGRAM_DEPTH + 1);
  localparam int unsigned DA = $clog2(DATA_DEPTH);
  localparam int unsigned LA = $clog2(LOOP_DEPTH);

  slbm_pkg::cmd_t cmd;
  slbm_pkg::sts_t sts;
  logic [PA-1:0] prog_waddr;
  logic [30:0]   prog_wdata;
  logic [PA-1:0] prog_raddr;
  logic [30:0]   prog_rdata;
  logic [DA-1:0] data_waddr;
  logic [DA-1:0] data_raddr;
  logic [30:0]   lit;
  logic [LA-1:0] stack_widx;
  logic [LA-1:0] stack_ridx;
  logic [IW-1:0] push_start;
  logic [DA-1:0] push_reg;
  logic [IW-1:0] top_start;
  logic [DA-1:0] top_reg;

  slbm_ctrl #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .DATA_DEPTH    (DATA_DEPTH),
    .LOOP_DEPTH    (LOOP_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_cmd     (in_ch.cmd),
    .in_word    (in_ch.word),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .cmd        (cmd),
    .sts        (sts),
    .prog_waddr (prog_waddr),
    .prog_wdata (prog_wdata),
    .prog_raddr (prog_raddr),
    .prog_rdata (prog_rdata),
    .data_waddr (data_waddr),
    .data_raddr (data_raddr),
    .lit        (lit),
    .stack_widx (stack_widx),
    .stack_ridx (stack_ridx),
    .push_start (push_start),
    .push_reg   (push_reg),
    .top_start  (top_start),
    .top_reg    (top_reg)
  );

  slbm_dp #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .DATA_DEPTH    (DATA_DEPTH),
    .LOOP_DEPTH    (LOOP_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .prog_waddr (prog_waddr),
    .prog_wdata (prog_wdata),
    .prog_raddr (prog_raddr),
    .prog_rdata (prog_rdata),
    .data_waddr (data_waddr),
    .data_raddr (data_raddr),
    .lit        (lit),
    .stack_widx (stack_widx),
    .stack_ridx (stack_ridx),
    .push_start (push_start),
    .push_reg   (push_reg),
    .top_start  (top_start),
    .top_reg    (top_reg),
    .value      (out_ch.value)
  );

`ifndef SYNTHESIS
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ch.ready)
    else $error("request taken during memory sweep");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second request taken while one is in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("result pending while idle");

  a_value_only_on_show: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != 3'(slbm_pkg::ST_SHOW)) |-> out_ch.value == 32'd0)
    else $error("value set without a show");
`endif

endmodule

@@ sim/slbm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbm_checker
// Watches both channels of the bytecode machine, predicts the result of each
// accepted request from its own copy of the machine state, and compares every
// result field by field with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module slbm_checker #(
  parameter int unsigned PROGRAM_DEPTH = 1024,
  parameter int unsigned DATA_DEPTH    = 1024,
  parameter int unsigned LOOP_DEPTH    = 16
) (
  input  logic clk,
  input  logic rst,
  slbm_in_if   in_ch,
  slbm_out_if  out_ch,
  output int   errors,
  output int   outstanding
);

  localparam logic [30:0] OP_LAST = 31'(slbm_pkg::OP_MOD);

  typedef struct {
    slbm_pkg::status_t st;
    logic [31:0]       v;
  } result_t;

  result_t     expected_q[$];
  logic [30:0] prog_mem[PROGRAM_DEPTH];
  logic [31:0] data_mem[DATA_DEPTH];
  int unsigned prog_len;
  int unsigned ip;
  int unsigned skip;
  int unsigned loop_start[LOOP_DEPTH];
  int unsigned loop_reg[LOOP_DEPTH];
  int unsigned level;
  logic        halted;

  assign outstanding = expected_q.size();

  function automatic int unsigned operands_of(input logic [3:0] op);
    int unsigned n;
    case (slbm_pkg::op_t'(op))
      slbm_pkg::OP_END:                                      n = 0;
      slbm_pkg::OP_WHILE, slbm_pkg::OP_SHOW, slbm_pkg::OP_NOT: n = 1;
      slbm_pkg::OP_SET, slbm_pkg::OP_COPY:                   n = 2;
      default:                                               n = 3;
    endcase
    return n;
  endfunction

  task automatic signed_divide(input logic [31:0] x, input logic [31:0] y,
                               output logic [31:0] q, output logic [31:0] r);
    logic [31:0] ux, uy, mq, mr;
    ux = x[31] ? -x : x;
    uy = y[31] ? -y : y;
    mq = ux / uy;
    mr = ux % uy;
    q  = (x[31] ^ y[31]) ? -mq : mq;
    r  = x[31] ? -mr : mr;
  endtask

  task automatic loop_back(output slbm_pkg::status_t st);
    int unsigned top;
    st = slbm_pkg::ST_OK;
    if (level == 0) begin
      if (data_mem[0] != 0) ip = 0;
      else begin
        halted = 1'b1;
        st = slbm_pkg::ST_HALT;
      end
    end else begin
      top = level - 1;
      if (data_mem[loop_reg[top]] != 0) ip = loop_start[top];
      else level--;
    end
  endtask

  task automatic run_instr(input logic [3:0] op, input logic [30:0] a, input logic [30:0] b,
                           input logic [30:0] t, output slbm_pkg::status_t st,
                           output logic [31:0] v);
    logic [31:0] x, y, res, q, r;
    st = slbm_pkg::ST_OK;
    v = '0;
    res = '0;
    case (slbm_pkg::op_t'(op))
      slbm_pkg::OP_END: loop_back(st);
      slbm_pkg::OP_WHILE: begin
        if (a >= DATA_DEPTH) begin
          skip = 1;
          st = slbm_pkg::ST_RANGE;
        end else if (data_mem[a] == 0) skip = 1;
        else if (level >= LOOP_DEPTH) begin
          skip = 1;
          st = slbm_pkg::ST_OVF;
        end else begin
          loop_start[level] = ip;
          loop_reg[level] = a;
          level++;
        end
      end
      slbm_pkg::OP_SET: begin
        if (a >= DATA_DEPTH) st = slbm_pkg::ST_RANGE;
        else data_mem[a] = {1'b0, b};
      end
      slbm_pkg::OP_COPY: begin
        if (a >= DATA_DEPTH || b >= DATA_DEPTH) st = slbm_pkg::ST_RANGE;
        else data_mem[a] = data_mem[b];
      end
      slbm_pkg::OP_SHOW: begin
        if (a >= DATA_DEPTH) st = slbm_pkg::ST_RANGE;
        else begin
          v = data_mem[a];
          st = slbm_pkg::ST_SHOW;
        end
      end
      slbm_pkg::OP_NOT: begin
        if (a >= DATA_DEPTH) st = slbm_pkg::ST_RANGE;
        else data_mem[a] = (data_mem[a] == 0) ? 32'd1 : 32'd0;
      end
      default: begin
        if (a >= DATA_DEPTH || b >= DATA_DEPTH || t >= DATA_DEPTH) st = slbm_pkg::ST_RANGE;
        else begin
          x = data_mem[a];
          y = data_mem[b];
          case (slbm_pkg::op_t'(op))
            slbm_pkg::OP_ADD: res = x + y;
            slbm_pkg::OP_SUB: res = x - y;
            slbm_pkg::OP_MUL: res = x * y;
            slbm_pkg::OP_DIV, slbm_pkg::OP_MOD: begin
              if (y == 0) st = slbm_pkg::ST_DIVZ;
              else begin
                signed_divide(x, y, q, r);
                res = (slbm_pkg::op_t'(op) == slbm_pkg::OP_DIV) ? q : r;
              end
            end
            slbm_pkg::OP_EQ: res = (x == y) ? 32'd1 : 32'd0;
            slbm_pkg::OP_GT: res = ($signed(x) > $signed(y)) ? 32'd1 : 32'd0;
            default:         res = (x != 0 || y != 0) ? 32'd1 : 32'd0;
          endcase
          if (st == slbm_pkg::ST_OK) data_mem[t] = res;
        end
      end
    endcase
  endtask

  task automatic predict_request(input logic c, input logic [30:0] w,
                                 output slbm_pkg::status_t st, output logic [31:0] v);
    logic [30:0] op, a, b, t;
    int unsigned n, nxt;
    st = slbm_pkg::ST_OK;
    v = '0;
    if (!c) begin
      if (prog_len < PROGRAM_DEPTH) begin
        prog_mem[prog_len] = w;
        prog_len++;
      end else st = slbm_pkg::ST_RANGE;
    end else if (halted) st = slbm_pkg::ST_HALT;
    else if (ip >= prog_len) begin
      skip = 0;
      loop_back(st);
    end else begin
      op = prog_mem[ip];
      if (op > OP_LAST) begin
        st = slbm_pkg::ST_BADOP;
        ip++;
      end else if (skip > 0) begin
        nxt = ip + 1 + operands_of(op[3:0]);
        if (slbm_pkg::op_t'(op[3:0]) == slbm_pkg::OP_END) skip--;
        else if (slbm_pkg::op_t'(op[3:0]) == slbm_pkg::OP_WHILE && skip < slbm_pkg::SKIP_MAX)
          skip++;
        ip = (nxt < prog_len) ? nxt : prog_len;
      end else begin
        n = operands_of(op[3:0]);
        if (ip + n >= prog_len) begin
          st = slbm_pkg::ST_RANGE;
          ip = prog_len;
        end else begin
          a = (n >= 1) ? prog_mem[ip+1] : '0;
          b = (n >= 2) ? prog_mem[ip+2] : '0;
          t = (n >= 3) ? prog_mem[ip+3] : '0;
          ip = ip + 1 + n;
          run_instr(op[3:0], a, b, t, st, v);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    result_t pred;
    result_t exp_r;
    if (rst) begin
      expected_q.delete();
      for (int i = 0; i < DATA_DEPTH; i++) data_mem[i] = '0;
      data_mem[0] = 32'd1;
      prog_len = 0;
      ip = 0;
      skip = 0;
      level = 0;
      halted = 1'b0;
      errors <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_request(in_ch.cmd, in_ch.word, pred.st, pred.v);
        expected_q.push_back(pred);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: status %0d value %h", out_ch.status, out_ch.value);
          errors <= errors + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_ch.status !== exp_r.st || out_ch.value !== exp_r.v) begin
            if (errors < 10)
              $display("mismatch: expected status %0d value %h, got status %0d value %h",
                       exp_r.st, exp_r.v, out_ch.status, out_ch.value);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the bytecode machine with a directed program and then random
// structured programs interleaved with steps, with random idling on both
// channels and one long result stall; finally runs the machine into a halt.
// The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RANDOM_ITEMS  = 80;
  localparam logic [30:0] BAD_OP_WORD   = 31'd14;

  logic clk;
  logic rst;
  int   errors;
  int   outstanding;
  int   n_items;
  logic quiet;
  logic hold_req;
  int   wait_cnt;

  logic [30:0] word_q[$];

  slbm_in_if  in_ch ();
  slbm_out_if out_ch ();

  structured_loop_bytecode_machine_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  slbm_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, one long hold-off
  initial begin
    int burst;
    int hold;
    logic hold_done;
    burst = 0;
    hold = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (burst > 0) begin
        out_ch.ready <= 1'b0;
        burst--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(0, 4);
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_request(input logic c, input logic [30:0] w);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.word  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
  endtask

  task automatic load_word(input logic [30:0] w);
    send_request(1'b0, w);
  endtask

  task automatic step_once();
    send_request(1'b1, 31'($urandom));
  endtask

  function automatic logic [30:0] pick_target();
    if ($urandom_range(0, 9) == 0) return 31'($urandom) | 31'd1024;
    return 31'($urandom_range(1, 7));
  endfunction

  function automatic logic [30:0] pick_source();
    if ($urandom_range(0, 9) == 0) return 31'($urandom) | 31'd1024;
    return 31'($urandom_range(0, 15));
  endfunction

  task automatic queue_plain();
    slbm_pkg::op_t op;
    op = slbm_pkg::op_t'($urandom_range(slbm_pkg::OP_SET, slbm_pkg::OP_MOD));
    word_q.push_back(31'(op));
    case (op)
      slbm_pkg::OP_SET: begin
        word_q.push_back(pick_target());
        word_q.push_back($urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 3)));
      end
      slbm_pkg::OP_COPY: begin
        word_q.push_back(pick_target());
        word_q.push_back(pick_source());
      end
      slbm_pkg::OP_SHOW: word_q.push_back(pick_source());
      slbm_pkg::OP_NOT:  word_q.push_back(pick_target());
      default: begin
        word_q.push_back(pick_source());
        word_q.push_back(pick_source());
        word_q.push_back(pick_target());
      end
    endcase
  endtask

  // loop body ends by clearing its test register when in range, so every loop exits
  task automatic queue_loop(input int nest);
    logic [30:0] r;
    int body;
    r = ($urandom_range(0, 9) == 0) ? (31'($urandom) | 31'd1024)
                                    : 31'($urandom_range(1, 7));
    if (r < 1024 && $urandom_range(0, 1)) begin
      word_q.push_back(31'(slbm_pkg::OP_SET));
      word_q.push_back(r);
      word_q.push_back(31'($urandom_range(1, 9)));
    end
    word_q.push_back(31'(slbm_pkg::OP_WHILE));
    word_q.push_back(r);
    body = $urandom_range(1, 3);
    repeat (body) queue_plain();
    if (nest > 0 && $urandom_range(0, 2) == 0) queue_loop(nest - 1);
    if (r < 1024) begin
      word_q.push_back(31'(slbm_pkg::OP_SET));
      word_q.push_back(r);
      word_q.push_back(31'd0);
    end
    word_q.push_back(31'(slbm_pkg::OP_END));
  endtask

  task automatic queue_overflow();
    word_q.push_back(31'(slbm_pkg::OP_SET));
    word_q.push_back(31'd1);
    word_q.push_back(31'd1);
    word_q.push_back(31'(slbm_pkg::OP_SET));
    word_q.push_back(31'd2);
    word_q.push_back(31'd1);
    repeat (16) begin
      word_q.push_back(31'(slbm_pkg::OP_WHILE));
      word_q.push_back(31'd1);
    end
    word_q.push_back(31'(slbm_pkg::OP_SET));
    word_q.push_back(31'd1);
    word_q.push_back(31'd0);
    word_q.push_back(31'(slbm_pkg::OP_WHILE));
    word_q.push_back(31'd2);
    word_q.push_back(31'(slbm_pkg::OP_SET));
    word_q.push_back(31'd2);
    word_q.push_back(31'd0);
    repeat (17) word_q.push_back(31'(slbm_pkg::OP_END));
  endtask

  initial begin
    int target;
    logic overflow_done;
    n_items = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    overflow_done = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd   = 1'b0;
    in_ch.word  = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // loop-back on an empty program
    step_once();
    // directed program: every operation, wrapping, range, zero divide, skips
    word_q = '{31'(slbm_pkg::OP_SET), 31'd1, 31'd5,
               31'(slbm_pkg::OP_SET), 31'd2, 31'h7FFF_FFFF,
               31'(slbm_pkg::OP_ADD), 31'd1, 31'd2, 31'd3,
               31'(slbm_pkg::OP_MUL), 31'd3, 31'd2, 31'd3,
               31'(slbm_pkg::OP_DIV), 31'd1, 31'd4, 31'd5,
               31'(slbm_pkg::OP_SET), 31'd5, 31'h4000_0000,
               31'(slbm_pkg::OP_ADD), 31'd5, 31'd5, 31'd5,
               31'(slbm_pkg::OP_SUB), 31'd4, 31'd1, 31'd6,
               31'(slbm_pkg::OP_NOT), 31'd4,
               31'(slbm_pkg::OP_SUB), 31'd9, 31'd4, 31'd6,
               31'(slbm_pkg::OP_DIV), 31'd5, 31'd6, 31'd8,
               31'(slbm_pkg::OP_MOD), 31'd5, 31'd6, 31'd10,
               31'(slbm_pkg::OP_MOD), 31'd1, 31'd9, 31'd10,
               31'(slbm_pkg::OP_SHOW), 31'd8,
               31'(slbm_pkg::OP_EQ), 31'd1, 31'd1, 31'd11,
               31'(slbm_pkg::OP_GT), 31'd6, 31'd1, 31'd11,
               31'(slbm_pkg::OP_OR), 31'd9, 31'd12, 31'd11,
               31'(slbm_pkg::OP_COPY), 31'd12, 31'd5,
               31'(slbm_pkg::OP_COPY), 31'd12, 31'h7FFF_FFFF,
               31'(slbm_pkg::OP_SHOW), 31'd2000,
               31'h7FFF_FFFF,
               31'(slbm_pkg::OP_WHILE), 31'd13,
               31'(slbm_pkg::OP_WHILE), 31'd1,
               BAD_OP_WORD,
               31'(slbm_pkg::OP_END),
               31'(slbm_pkg::OP_END),
               31'(slbm_pkg::OP_WHILE), 31'd3000,
               31'(slbm_pkg::OP_SHOW), 31'd1,
               31'(slbm_pkg::OP_END)};
    while (word_q.size() > 0) load_word(word_q.pop_front());
    repeat (40) step_once();

    target = n_items + RANDOM_ITEMS;
    while (n_items < target) begin
      if (n_items > 130) hold_req = 1'b1;
      if (word_q.size() == 0) begin
        if (!overflow_done && n_items > 160) begin
          overflow_done = 1'b1;
          queue_overflow();
        end else begin
          case ($urandom_range(0, 19))
            0:       word_q.push_back(31'($urandom) | 31'h10);
            1, 2, 3: queue_loop(1);
            default: queue_plain();
          endcase
        end
      end
      if ($urandom_range(0, 1)) load_word(word_q.pop_front());
      else step_once();
    end
    while (word_q.size() > 0) load_word(word_q.pop_front());

    // halt: clear data word 0 at the program end, then run into the halt
    quiet = 1'b1;
    load_word(31'(slbm_pkg::OP_SET));
    load_word(31'd0);
    load_word(31'd0);
    repeat (160) step_once();
    in_ch.valid <= 1'b0;

    wait_cnt = 0;
    while (outstanding > 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (outstanding > 0) begin
      $display("FAIL");
      $finish;
    end else begin
      repeat (60) @(posedge clk);
      if (errors == 0 && outstanding == 0) $display("PASS");
      else $display("FAIL");
      $finish;
    end
  end

endmodule
